// File: rtl/core/sact_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sact_pkg;

    // Geometry of the tag store
    localparam int SETS     = 64;
    localparam int WAYS     = 8;
    localparam int TAG_BITS = 20;

    localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int AGE_W = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int WIU_W = 4;

    // ways_in_use after reset, and the age every way starts at
    localparam logic [WIU_W-1:0] WIU_RESET = WIU_W'((WAYS < 8) ? WAYS : 8);
    localparam logic [AGE_W-1:0] AGE_RESET = AGE_W'(((WAYS < 8) ? WAYS : 8) - 1);

    typedef enum logic [1:0] {
        ACT_LOOKUP = 2'd0,
        ACT_TOUCH  = 2'd1,
        ACT_VICTIM = 2'd2,
        ACT_FILL   = 2'd3
    } t_action;

    typedef enum logic {
        ST_IDLE,
        ST_RMW
    } t_state;

    typedef struct packed {
        t_action     action;
        logic [5:0]  set_index;
        logic [2:0]  way_select;
        logic [19:0] tag_value;
    } t_in_item;

    typedef struct packed {
        logic [3:0] way_result;
        logic       found;
    } t_out_item;

    // One set: all ways side by side
    typedef struct packed {
        logic [WAYS-1:0]                valid;
        logic [WAYS-1:0][TAG_BITS-1:0]  tag;
        logic [WAYS-1:0][AGE_W-1:0]     age;
    } t_row;

    localparam int ROW_W = $bits(t_row);

endpackage

`default_nettype wire

// File: rtl/core/sact_row_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module sact_row_ram (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [sact_pkg::SET_W-1:0] i_waddr,
    input  wire sact_pkg::t_row           i_wdata,
    input  wire logic                     i_re,
    input  wire logic [sact_pkg::SET_W-1:0] i_raddr,
    output sact_pkg::t_row                o_rdata
);
    import sact_pkg::*;

    t_row r_mem [SETS];
    t_row r_rdata;

    // Write one set row
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read, held while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: rtl/core/sact_set_logic.sv
`timescale 1ns / 1ps
`default_nettype none

module sact_set_logic (
    input  wire sact_pkg::t_in_item       i_item,
    input  wire sact_pkg::t_row           i_row,
    input  wire logic [sact_pkg::WIU_W-1:0] i_wiu,
    output sact_pkg::t_row                o_row,
    output sact_pkg::t_out_item           o_out
);
    import sact_pkg::*;

    logic [AGE_W-1:0] ref_age;
    logic [3:0]       way;
    logic             hit;
    t_row             n_row;

    assign ref_age = i_row.age[i_item.way_select];

    // Compare all ways of the set and build the updated row
    always_comb begin
        n_row = i_row;
        way   = i_wiu;
        hit   = 1'b0;
        unique case (i_item.action)
            ACT_LOOKUP: begin
                for (int i = 0; i < WAYS; i++) begin
                    if (!hit && (WIU_W'(i) < i_wiu) && i_row.valid[i] &&
                        (i_row.tag[i] == i_item.tag_value[TAG_BITS-1:0])) begin
                        way = 4'(i);
                        hit = 1'b1;
                    end
                end
            end
            ACT_VICTIM: begin
                // first invalid way, else first way at the oldest age
                for (int i = 0; i < WAYS; i++) begin
                    if (!hit && (WIU_W'(i) < i_wiu) && !i_row.valid[i]) begin
                        way = 4'(i);
                        hit = 1'b1;
                    end
                end
                for (int i = 0; i < WAYS; i++) begin
                    if (!hit && (WIU_W'(i) < i_wiu) &&
                        (WIU_W'(i_row.age[i]) == (i_wiu - 1'b1))) begin
                        way = 4'(i);
                        hit = 1'b1;
                    end
                end
            end
            ACT_TOUCH, ACT_FILL: begin
                if (WIU_W'(i_item.way_select) < i_wiu) begin
                    // age the ways younger than the touched one
                    for (int i = 0; i < WAYS; i++) begin
                        if ((WIU_W'(i) < i_wiu) && (i_row.age[i] < ref_age)) begin
                            n_row.age[i] = i_row.age[i] + 1'b1;
                        end
                    end
                    n_row.age[i_item.way_select] = '0;
                    if (i_item.action == ACT_FILL) begin
                        n_row.valid[i_item.way_select] = 1'b1;
                        n_row.tag[i_item.way_select]   = i_item.tag_value[TAG_BITS-1:0];
                    end
                    way = 4'(i_item.way_select);
                    hit = 1'b1;
                end
            end
        endcase
    end

    assign o_row            = n_row;
    assign o_out.way_result = way;
    assign o_out.found      = hit;

endmodule

`default_nettype wire

// File: rtl/core/set_assoc_cache_tags_lru.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Signals                              Direction
// config    i_cfg_we, i_cfg_data                 in, write only
// item in   i_in_valid, o_in_ready, i_in_item    in
// result    o_out_valid, i_out_ready, o_out_item out
//
// Each item has its set row read from the registered row RAM in the idle
// state, then is compared, updated and written back in the read-modify-write
// state. A waiting result in the output register does not block the next
// read; the write-back holds until the output register is free. Reset marks
// every set row as unwritten in flip-flops, so an unwritten row reads as all
// invalid at the reset age.

module set_assoc_cache_tags_lru (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [3:0]           i_cfg_data,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire sact_pkg::t_in_item   i_in_item,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output sact_pkg::t_out_item       o_out_item
);
    import sact_pkg::*;

    t_state           r_state;
    t_state           n_state;
    logic [WIU_W-1:0] r_wiu;
    logic [SETS-1:0]  r_row_vld;
    logic             r_rd_vld;
    t_in_item         r_item;
    logic             r_out_valid;
    t_out_item        r_out;

    logic             accept;
    logic             finish;
    logic [SET_W-1:0] in_row;
    logic [SET_W-1:0] cur_row;
    t_row             ram_rdata;
    t_row             eff_row;
    t_row             new_row;
    t_out_item        res;

    assign in_row  = SET_W'(i_in_item.set_index % SETS);
    assign cur_row = SET_W'(r_item.set_index % SETS);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_in_valid) n_state = ST_RMW;
            ST_RMW:  if (!r_out_valid || i_out_ready) n_state = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb begin
        o_in_ready = 1'b0;
        finish     = 1'b0;
        unique case (r_state)
            ST_IDLE: o_in_ready = 1'b1;
            ST_RMW:  finish     = !r_out_valid || i_out_ready;
        endcase
    end

    assign accept = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Clamp the ways-in-use register to 1..WAYS
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wiu <= WIU_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_data == '0) begin
                r_wiu <= WIU_W'(1);
            end else if (i_cfg_data > WIU_W'(WAYS)) begin
                r_wiu <= WIU_W'(WAYS);
            end else begin
                r_wiu <= i_cfg_data;
            end
        end
    end

    // Track which set rows have been written since reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
            r_rd_vld  <= 1'b0;
        end else begin
            if (accept) begin
                r_rd_vld <= r_row_vld[in_row];
            end
            if (finish) begin
                r_row_vld[cur_row] <= 1'b1;
            end
        end
    end

    // Hold the item under work
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_in_item;
        end
    end

    sact_row_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (finish),
        .i_waddr (cur_row),
        .i_wdata (new_row),
        .i_re    (accept),
        .i_raddr (in_row),
        .o_rdata (ram_rdata)
    );

    // Unwritten rows read as the reset contents
    always_comb begin
        eff_row = ram_rdata;
        if (!r_rd_vld) begin
            eff_row.valid = '0;
            eff_row.tag   = '0;
            for (int i = 0; i < WAYS; i++) begin
                eff_row.age[i] = AGE_RESET;
            end
        end
    end

    sact_set_logic u_logic (
        .i_item (r_item),
        .i_row  (eff_row),
        .i_wiu  (r_wiu),
        .o_row  (new_row),
        .o_out  (res)
    );

    // Output register: load on write-back, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

`default_nettype wire
